### rtl/dtlr_pkg.sv
// ----------------------------------------------------------------------------
// dtlr_pkg
// Shared types and constants of the depth-tested line rasterizer.
// ----------------------------------------------------------------------------
package dtlr_pkg;

    localparam int FB_WIDTH_DEF   = 256;
    localparam int FB_HEIGHT_DEF  = 256;
    localparam int DEPTH_BITS_DEF = 24;
    localparam int COORD_BITS_DEF = 12;
    localparam int OP_BITS        = 3;
    localparam int COLOR_BITS     = 24;
    localparam int COUNT_BITS     = 13;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_DRAW_LINE   = 3'd0,
        OP_WRITE_PIXEL = 3'd1,
        OP_CLEAR_COLOR = 3'd2,
        OP_CLEAR_DEPTH = 3'd3,
        OP_READ_PIXEL  = 3'd4
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SETUP,
        ST_DIVIDE,
        ST_READ,
        ST_TEST,
        ST_STEP,
        ST_PIXEL,
        ST_PREAD,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

### rtl/dtlr_front.sv
// ----------------------------------------------------------------------------
// dtlr_front
// Accepts command items and queues them for the back end.
// ----------------------------------------------------------------------------
module dtlr_front
    import dtlr_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int DB = DEPTH_BITS_DEF,
    parameter int W  = OP_BITS + 1 + 4 * CB + 2 * DB + COLOR_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem_reg [QUEUE_DEPTH];
    logic         wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ (push && !full);
        rp_next  = rp_reg ^ (pop && !empty);
        cnt_next = cnt_reg + 2'(push && !full) - 2'(pop && !empty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= push_data;
    end

endmodule

### rtl/dtlr_back.sv
// ----------------------------------------------------------------------------
// dtlr_back
// Executes commands against the colour and depth memories.
// ----------------------------------------------------------------------------
module dtlr_back
    import dtlr_pkg::*;
#(
    parameter int FW = FB_WIDTH_DEF,
    parameter int FH = FB_HEIGHT_DEF,
    parameter int DB = DEPTH_BITS_DEF,
    parameter int CB = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_pop,
    input  logic [OP_BITS-1:0]    cmd_op,
    input  logic                  cmd_in_frame,
    input  logic signed [CB-1:0]  cmd_x0,
    input  logic signed [CB-1:0]  cmd_y0,
    input  logic signed [CB-1:0]  cmd_x1,
    input  logic signed [CB-1:0]  cmd_y1,
    input  logic [DB-1:0]         cmd_z0,
    input  logic [DB-1:0]         cmd_z1,
    input  logic [COLOR_BITS-1:0] cmd_color,
    output logic                  idle,
    output logic                  done,
    output logic [COLOR_BITS-1:0] res_color,
    output logic [DB-1:0]         res_depth,
    output logic [COUNT_BITS-1:0] res_count,
    output logic                  res_status
);

    localparam int N  = FW * FH;
    localparam int AB = (N > 1) ? $clog2(N) : 1;
    localparam int XB = (FW > 1) ? $clog2(FW) : 1;
    localparam int YB = (FH > 1) ? $clog2(FH) : 1;
    localparam int EB = CB + 3;
    localparam int QB = DB + CB + 2;

    logic [COLOR_BITS-1:0] cmem [N];
    logic [DB-1:0]         zmem [N];

    state_t state_reg, state_next;
    logic [AB:0]           ptr_reg, ptr_next;
    logic [OP_BITS-1:0]    op_reg;
    logic signed [EB-1:0]  x_reg, y_reg, x1_reg, y1_reg, dx_reg, dy_reg, err_reg;
    logic                  sx_reg, sy_reg;
    logic [CB:0]           span_reg, k_reg;
    logic [DB-1:0]         z0_reg, fill_z_reg;
    logic [COLOR_BITS-1:0] col_reg;
    logic                  neg_reg;
    logic [QB-1:0]         num_reg, rem_reg;
    logic [DB-1:0]         quo_reg, dmag_reg;
    logic [5:0]            bit_reg;
    logic [DB-1:0]         pz_reg;
    logic [COLOR_BITS-1:0] rd_col_reg;
    logic [DB-1:0]         rd_z_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  stat_reg, inf_reg, rdop_reg;
    logic [COLOR_BITS-1:0] rc_reg;
    logic [DB-1:0]         rz_reg;

    logic                  in_f;
    logic [AB-1:0]         addr;
    logic [QB-1:0]         rem_sh;
    logic signed [EB:0]    e2;

    assign in_f = (x_reg >= 0) && (32'(x_reg) < FW) && (y_reg >= 0) && (32'(y_reg) < FH);
    assign addr = AB'(y_reg[YB-1:0]) * AB'(FW) + AB'(x_reg[XB-1:0]);
    assign rem_sh = {rem_reg[QB-2:0], num_reg[QB-1]};
    assign e2 = {err_reg, 1'b0};
    assign idle = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:   state_next = (ptr_reg == (AB+1)'(N - 1)) ? ST_IDLE : ST_INIT;
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_op)
                        OP_DRAW_LINE:   state_next = ST_SETUP;
                        OP_WRITE_PIXEL: state_next = ST_PIXEL;
                        OP_READ_PIXEL:  state_next = ST_PREAD;
                        OP_CLEAR_COLOR,
                        OP_CLEAR_DEPTH: state_next = ST_CLEAR;
                        default:        state_next = ST_DONE;
                    endcase
                end
            end
            ST_SETUP:  state_next = ST_DIVIDE;
            ST_DIVIDE: state_next = (bit_reg == 6'd0) ? ST_READ : ST_DIVIDE;
            ST_READ:   state_next = ST_TEST;
            ST_TEST:   state_next = ST_STEP;
            ST_STEP:   state_next = (x_reg == x1_reg && y_reg == y1_reg) ? ST_DONE : ST_DIVIDE;
            ST_PIXEL:  state_next = ST_DONE;
            ST_PREAD:  state_next = ST_DONE;
            ST_CLEAR:  state_next = (ptr_reg == (AB+1)'(N - 1)) ? ST_DONE : ST_CLEAR;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;
        ptr_next = (state_reg == ST_INIT || state_reg == ST_CLEAR) ? ptr_reg + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ptr_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            done      <= (state_reg == ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_INIT:
            begin
                cmem[ptr_reg[AB-1:0]] <= '0;
                zmem[ptr_reg[AB-1:0]] <= '1;
            end
            ST_IDLE:
            begin
                op_reg   <= cmd_op;
                x_reg    <= EB'(cmd_x0);
                y_reg    <= EB'(cmd_y0);
                x1_reg   <= EB'(cmd_x1);
                y1_reg   <= EB'(cmd_y1);
                z0_reg   <= cmd_z0;
                fill_z_reg <= cmd_z0;
                col_reg  <= cmd_color;
                inf_reg  <= cmd_in_frame;
                cnt_reg  <= '0;
                k_reg    <= '0;
                dx_reg   <= (EB'(cmd_x1) > EB'(cmd_x0)) ? EB'(cmd_x1) - EB'(cmd_x0)
                                                       : EB'(cmd_x0) - EB'(cmd_x1);
                dy_reg   <= (EB'(cmd_y1) > EB'(cmd_y0)) ? EB'(cmd_y1) - EB'(cmd_y0)
                                                       : EB'(cmd_y0) - EB'(cmd_y1);
                sx_reg   <= (cmd_x0 < cmd_x1);
                sy_reg   <= (cmd_y0 < cmd_y1);
                neg_reg  <= (cmd_z1 < cmd_z0);
                dmag_reg <= (cmd_z1 < cmd_z0) ? cmd_z0 - cmd_z1 : cmd_z1 - cmd_z0;
            end
            ST_SETUP:
            begin
                err_reg  <= dx_reg - dy_reg;
                span_reg <= (CB+1)'((dx_reg >= dy_reg) ? dx_reg : dy_reg);
                num_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= '0;
                bit_reg  <= 6'(QB + 1);
            end
            ST_DIVIDE:
            begin
                if (bit_reg == 6'(QB + 1))
                begin
                    num_reg <= QB'(dmag_reg) * QB'(k_reg);
                    rem_reg <= '0;
                    quo_reg <= '0;
                    bit_reg <= bit_reg - 1'b1;
                end
                else if (bit_reg != 6'd0)
                begin
                    num_reg <= {num_reg[QB-2:0], 1'b0};
                    if (span_reg != '0 && rem_sh >= QB'(span_reg))
                    begin
                        rem_reg <= rem_sh - QB'(span_reg);
                        quo_reg <= {quo_reg[DB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DB-2:0], 1'b0};
                    end
                    bit_reg <= bit_reg - 1'b1;
                end
            end
            ST_READ:
            begin
                pz_reg   <= (span_reg == '0) ? z0_reg
                          : neg_reg ? z0_reg - quo_reg : z0_reg + quo_reg;
                rd_z_reg <= zmem[addr];
            end
            ST_TEST:
            begin
                if (in_f && pz_reg < rd_z_reg)
                begin
                    zmem[addr] <= pz_reg;
                    cmem[addr] <= col_reg;
                    cnt_reg    <= cnt_reg + 1'b1;
                end
            end
            ST_STEP:
            begin
                k_reg   <= k_reg + 1'b1;
                bit_reg <= 6'(QB + 1);
                if (e2 > -(EB+1)'(dy_reg) && e2 < (EB+1)'(dx_reg))
                    err_reg <= err_reg - dy_reg + dx_reg;
                else if (e2 > -(EB+1)'(dy_reg))
                    err_reg <= err_reg - dy_reg;
                else if (e2 < (EB+1)'(dx_reg))
                    err_reg <= err_reg + dx_reg;
                if (e2 > -(EB+1)'(dy_reg))
                    x_reg <= sx_reg ? x_reg + 1'b1 : x_reg - 1'b1;
                if (e2 < (EB+1)'(dx_reg))
                    y_reg <= sy_reg ? y_reg + 1'b1 : y_reg - 1'b1;
            end
            ST_PIXEL:
            begin
                if (inf_reg)
                begin
                    zmem[addr] <= z0_reg;
                    cmem[addr] <= col_reg;
                end
            end
            ST_PREAD:
            begin
                rd_col_reg <= cmem[addr];
                rd_z_reg   <= zmem[addr];
            end
            ST_CLEAR:
            begin
                if (op_reg == OP_CLEAR_COLOR)
                    cmem[ptr_reg[AB-1:0]] <= col_reg;
                else
                    zmem[ptr_reg[AB-1:0]] <= fill_z_reg;
            end
            ST_DONE:
            begin
                rdop_reg <= (op_reg == OP_READ_PIXEL) && inf_reg;
                stat_reg <= (op_reg == OP_WRITE_PIXEL || op_reg == OP_READ_PIXEL) && !inf_reg;
                rc_reg   <= rd_col_reg;
                rz_reg   <= rd_z_reg;
                if (op_reg != OP_DRAW_LINE)
                    cnt_reg <= '0;
            end
            default: ;
        endcase
    end

    assign res_color  = rdop_reg ? rc_reg : '0;
    assign res_depth  = rdop_reg ? rz_reg : '0;
    assign res_count  = cnt_reg;
    assign res_status = stat_reg;

endmodule

### rtl/depth_tested_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// depth_tested_line_rasterizer_core
// Bresenham line drawing with per-pixel depth test into on-chip stores.
//
//   channel  | handshake           | payload
//   command  | start / busy        | opcode, coordinates, depths, colour
//   result   | done (one cycle)    | read_*, pixels_written, status
//
// A line runs a setup step, then per pixel a bit-serial depth division, a
// depth read, a depth test and a Bresenham step. Clears write one entry a cycle
// over all FB_WIDTH * FB_HEIGHT entries. After reset a clearing pass over all
// entries holds busy. The receiver cannot stall; done marks each result for one cycle.
// ----------------------------------------------------------------------------
module depth_tested_line_rasterizer_core
    import dtlr_pkg::*;
#(
    parameter int FB_WIDTH   = FB_WIDTH_DEF,
    parameter int FB_HEIGHT  = FB_HEIGHT_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [OP_BITS-1:0]           opcode,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic [DEPTH_BITS-1:0]        depth_start,
    input  logic [DEPTH_BITS-1:0]        depth_end,
    input  logic [7:0]                   red,
    input  logic [7:0]                   green,
    input  logic [7:0]                   blue,
    output logic                         done,
    output logic [7:0]                   read_red,
    output logic [7:0]                   read_green,
    output logic [7:0]                   read_blue,
    output logic [DEPTH_BITS-1:0]        read_depth,
    output logic [COUNT_BITS-1:0]        pixels_written,
    output logic                         status
);

    localparam int W = OP_BITS + 1 + 4 * COORD_BITS + 2 * DEPTH_BITS + COLOR_BITS;

    logic         full, empty, pop, bidle, inf;
    logic [W-1:0] qin, qout;
    logic [OP_BITS-1:0] q_op;
    logic         q_inf;
    logic signed [COORD_BITS-1:0] q_x0, q_y0, q_x1, q_y1;
    logic [DEPTH_BITS-1:0] q_z0, q_z1;
    logic [COLOR_BITS-1:0] q_col, rcol;
    logic         pend_reg, pend_next;

    assign inf = (x_start >= 0) && (32'(x_start) < FB_WIDTH)
              && (y_start >= 0) && (32'(y_start) < FB_HEIGHT);
    assign qin = {opcode, inf, x_start, y_start, x_end, y_end, depth_start, depth_end,
                  red, green, blue};
    assign {q_op, q_inf, q_x0, q_y0, q_x1, q_y1, q_z0, q_z1, q_col} = qout;

    // One command in flight at a time keeps stores consistent between items.
    assign busy = full || pend_reg || !bidle;
    assign pend_next = (start && !busy) ? 1'b1 : (done ? 1'b0 : pend_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= pend_next;
    end

    dtlr_front #(.CB(COORD_BITS), .DB(DEPTH_BITS), .W(W)) u_front (
        .clk(clk), .rst_n(rst_n), .push(start && !busy), .push_data(qin), .full(full),
        .pop(pop), .empty(empty), .pop_data(qout));

    dtlr_back #(.FW(FB_WIDTH), .FH(FB_HEIGHT), .DB(DEPTH_BITS), .CB(COORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(!empty), .cmd_pop(pop), .cmd_op(q_op),
        .cmd_in_frame(q_inf), .cmd_x0(q_x0), .cmd_y0(q_y0), .cmd_x1(q_x1), .cmd_y1(q_y1),
        .cmd_z0(q_z0), .cmd_z1(q_z1), .cmd_color(q_col), .idle(bidle), .done(done),
        .res_color(rcol), .res_depth(read_depth), .res_count(pixels_written),
        .res_status(status));

    assign read_red   = rcol[23:16];
    assign read_green = rcol[15:8];
    assign read_blue  = rcol[7:0];

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(start && !busy && $past(pend_reg) == 1'b0))
        else $error("item accepted while previous item pending");
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (read_depth == '0 && pixels_written == '0))
        else $error("flagged result carries data");

endmodule

### tb/sv/dtlr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlr_checker
// Watches the command and result channels of the line rasterizer, keeps its
// own copy of the colour and depth stores, predicts the result of every
// accepted item and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module dtlr_checker
    import dtlr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [OP_BITS-1:0]        opcode,
    input  logic signed [11:0]        x_start,
    input  logic signed [11:0]        y_start,
    input  logic signed [11:0]        x_end,
    input  logic signed [11:0]        y_end,
    input  logic [23:0]               depth_start,
    input  logic [23:0]               depth_end,
    input  logic [7:0]                red,
    input  logic [7:0]                green,
    input  logic [7:0]                blue,
    input  logic                      done,
    input  logic [7:0]                read_red,
    input  logic [7:0]                read_green,
    input  logic [7:0]                read_blue,
    input  logic [23:0]               read_depth,
    input  logic [COUNT_BITS-1:0]     pixels_written,
    input  logic                      status,
    output int                        mismatches,
    output int                        outstanding
);

    localparam int FBW = FB_WIDTH_DEF;
    localparam int FBH = FB_HEIGHT_DEF;

    typedef struct packed {
        logic [7:0]            r;
        logic [7:0]            g;
        logic [7:0]            b;
        logic [23:0]           d;
        logic [COUNT_BITS-1:0] n;
        logic                  s;
    } pixel_result_t;

    pixel_result_t expected_q[$];
    logic [23:0] color_mem [0:FBW*FBH-1];
    logic [23:0] depth_mem [0:FBW*FBH-1];

    function automatic bit on_screen(longint x, longint y);
        return x >= 0 && x < FBW && y >= 0 && y < FBH;
    endfunction

    function automatic int raster_line(longint x0, longint y0, longint x1, longint y1,
                                       logic [23:0] z0, logic [23:0] z1,
                                       logic [23:0] col);
        longint dx, dy, sx, sy, err, span, zd, x, y, k, e2;
        logic [23:0] z;
        int idx;
        int wr;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;
        err = dx - dy;
        span = (dx >= dy) ? dx : dy;
        zd = longint'(z1) - longint'(z0);
        x = x0;
        y = y0;
        wr = 0;
        for (k = 0; k <= span; k++)
        begin
            z = z0;
            if (span != 0)
                z = 24'(longint'(z0) + (zd * k) / span);
            if (on_screen(x, y))
            begin
                idx = int'(y) * FBW + int'(x);
                if (z < depth_mem[idx])
                begin
                    depth_mem[idx] = z;
                    color_mem[idx] = col;
                    wr++;
                end
            end
            if (x == x1 && y == y1)
                break;
            e2 = err * 2;
            if (e2 > -dy)
            begin
                err -= dy;
                x += sx;
            end
            if (e2 < dx)
            begin
                err += dx;
                y += sy;
            end
        end
        return wr;
    endfunction

    function automatic pixel_result_t run_command();
        pixel_result_t res;
        longint xs, ys;
        logic [23:0] col;
        int idx;
        res = '0;
        xs = longint'(x_start);
        ys = longint'(y_start);
        col = {red, green, blue};
        case (opcode)
            OP_DRAW_LINE:
                res.n = COUNT_BITS'(raster_line(xs, ys, longint'(x_end), longint'(y_end),
                                                depth_start, depth_end, col));
            OP_WRITE_PIXEL:
                if (on_screen(xs, ys))
                begin
                    idx = int'(ys) * FBW + int'(xs);
                    color_mem[idx] = col;
                    depth_mem[idx] = depth_start;
                end
                else
                    res.s = 1'b1;
            OP_CLEAR_COLOR:
                for (int i = 0; i < FBW * FBH; i++)
                    color_mem[i] = col;
            OP_CLEAR_DEPTH:
                for (int i = 0; i < FBW * FBH; i++)
                    depth_mem[i] = depth_start;
            OP_READ_PIXEL:
                if (on_screen(xs, ys))
                begin
                    idx = int'(ys) * FBW + int'(xs);
                    {res.r, res.g, res.b} = color_mem[idx];
                    res.d = depth_mem[idx];
                end
                else
                    res.s = 1'b1;
            default:
                ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t act;
        pixel_result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < FBW * FBH; i++)
            begin
                color_mem[i] = '0;
                depth_mem[i] = '1;
            end
            expected_q.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                act = '{read_red, read_green, read_blue, read_depth, pixels_written, status};
                if (expected_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("checker: result with no item pending: %p", act);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (act !== exp_r)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("checker: mismatch expected %p actual %p", exp_r, act);
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(run_command());
            outstanding <= expected_q.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random commands into the line rasterizer with random
// gaps, and reports the verdict from the checker's mismatch count, or NOT OK if the cycle limit is hit.
// ----------------------------------------------------------------------------
module tb_top;
    import dtlr_pkg::*;

    localparam longint CYCLE_LIMIT = 12000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [OP_BITS-1:0] opcode = '0;
    logic signed [11:0] x_start = '0;
    logic signed [11:0] y_start = '0;
    logic signed [11:0] x_end = '0;
    logic signed [11:0] y_end = '0;
    logic [23:0] depth_start = '0;
    logic [23:0] depth_end = '0;
    logic [7:0] red = '0;
    logic [7:0] green = '0;
    logic [7:0] blue = '0;
    logic done;
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic [23:0] read_depth;
    logic [COUNT_BITS-1:0] pixels_written;
    logic status;
    int mismatches;
    int outstanding;
    longint cycles = 0;

    always #6 clk = ~clk;

    depth_tested_line_rasterizer_core i_dut (.*);

    dtlr_checker i_checker (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic idle_gap();
        int k;
        int n;
        k = $urandom_range(0, 99);
        n = 0;
        if (k >= 95)
            n = $urandom_range(20, 300);
        else if (k >= 55)
            n = $urandom_range(1, 4);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [OP_BITS-1:0] op, input int xs, input int ys,
                         input int xe, input int ye, input logic [23:0] zs,
                         input logic [23:0] ze, input logic [23:0] col);
        opcode <= op;
        x_start <= 12'(xs);
        y_start <= 12'(ys);
        x_end <= 12'(xe);
        y_end <= 12'(ye);
        depth_start <= zs;
        depth_end <= ze;
        {red, green, blue} <= col;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        idle_gap();
    endtask

    function automatic int near_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)
            return $urandom_range(0, 40) - 4;
        return $urandom_range(0, 295) - 20;
    endfunction

    function automatic logic [23:0] rand_depth();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 24'($urandom_range(0, 15));
        if (k == 1)
            return 24'hFFFFFF - 24'($urandom_range(0, 15));
        return 24'($urandom());
    endfunction

    initial
    begin
        int k;
        int xs;
        int ys;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(OP_DRAW_LINE, 5, 5, 5, 5, 24'd100, 24'd900, 24'hFF0000);
        issue(OP_READ_PIXEL, 5, 5, 0, 0, '0, '0, '0);
        issue(OP_DRAW_LINE, 0, 10, 20, 10, 24'd0, 24'hFFFFFF, 24'h00FF00);
        issue(OP_DRAW_LINE, 20, 10, 0, 10, 24'd0, 24'hFFFFFF, 24'h0000FF);
        issue(OP_DRAW_LINE, 3, 0, 3, 30, 24'hFFFFFF, 24'd7, 24'hFFFFFF);
        issue(OP_DRAW_LINE, 30, 2, 2, 30, 24'd500, 24'd10, 24'h123456);
        issue(OP_DRAW_LINE, 30, 2, 2, 30, 24'd500, 24'd10, 24'hABCDEF);
        issue(OP_DRAW_LINE, 40, 0, 45, 25, 24'd3, 24'd3, 24'h808080);
        issue(OP_DRAW_LINE, -10, 250, 10, 265, 24'd50, 24'd60, 24'h010203);
        issue(OP_DRAW_LINE, -2048, -2048, 2047, 2047, 24'd1, 24'hFFFFFE, 24'h7F7F7F);
        issue(OP_WRITE_PIXEL, 255, 255, 0, 0, 24'hFFFFFF, '0, 24'hFFFFFF);
        issue(OP_WRITE_PIXEL, 0, 0, 0, 0, 24'd0, '0, 24'h000000);
        issue(OP_WRITE_PIXEL, -1, 0, 0, 0, 24'd1, '0, 24'h111111);
        issue(OP_WRITE_PIXEL, 0, 256, 0, 0, 24'd1, '0, 24'h222222);
        issue(OP_READ_PIXEL, 255, 255, 0, 0, '0, '0, '0);
        issue(OP_READ_PIXEL, 2047, -2048, 0, 0, '0, '0, '0);
        issue(OP_READ_PIXEL, 256, 10, 0, 0, '0, '0, '0);
        issue(OP_CLEAR_COLOR, 0, 0, 0, 0, '0, '0, 24'hA5C3E7);
        issue(OP_CLEAR_DEPTH, 0, 0, 0, 0, 24'd1000, '0, '0);
        issue(OP_DRAW_LINE, 0, 0, 15, 4, 24'd2000, 24'd0, 24'h5A5A5A);
        issue(OP_READ_PIXEL, 15, 4, 0, 0, '0, '0, '0);
        issue(3'd5, 1, 2, 3, 4, 24'd5, 24'd6, 24'h070809);
        issue(3'd6, 0, 0, 0, 0, '0, '0, '0);
        issue(3'd7, -1, -1, -1, -1, '1, '1, '1);
        issue(OP_CLEAR_DEPTH, 0, 0, 0, 0, 24'hFFFFFF, '0, '0);

        for (int i = 0; i < 1150; i++)
        begin
            if (i == 500)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            k = $urandom_range(0, 999);
            xs = near_coord();
            ys = near_coord();
            if (k < 500)
                issue(OP_DRAW_LINE, xs, ys, xs + $urandom_range(0, 24) - 12,
                      ys + $urandom_range(0, 24) - 12, rand_depth(), rand_depth(),
                      24'($urandom()));
            else if (k < 700)
                issue(OP_WRITE_PIXEL, (k % 10 == 0) ? $urandom() : xs,
                      (k % 10 == 1) ? $urandom() : ys, $urandom(), $urandom(),
                      rand_depth(), 24'($urandom()), 24'($urandom()));
            else if (k < 975)
                issue(OP_READ_PIXEL, (k % 10 == 0) ? $urandom() : xs,
                      (k % 10 == 1) ? $urandom() : ys, $urandom(), $urandom(),
                      24'($urandom()), 24'($urandom()), 24'($urandom()));
            else if (k < 978)
                issue(OP_CLEAR_COLOR, xs, ys, 0, 0, '0, '0, 24'($urandom()));
            else if (k < 981)
                issue(OP_CLEAR_DEPTH, xs, ys, 0, 0, rand_depth(), '0, '0);
            else
                issue(3'($urandom_range(5, 7)), $urandom(), $urandom(), $urandom(),
                      $urandom(), 24'($urandom()), 24'($urandom()), 24'($urandom()));
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### files.f
rtl/dtlr_pkg.sv
rtl/dtlr_front.sv
rtl/dtlr_back.sv
rtl/depth_tested_line_rasterizer_core.sv
tb/sv/dtlr_checker.sv
tb/sv/tb_top.sv
